/* design/jtkf_pkg.sv */
// shared types and constants of the json top-level key finder
package jtkf_pkg;

  // default parameter values
  localparam int KEY_BYTES_DEF         = 16;
  localparam int MAX_MESSAGE_BYTES_DEF = 32768;
  localparam int DEPTH_BITS_DEF        = 16;

  // fixed field widths
  localparam int BYTE_W   = 8;
  localparam int KEY_W    = 64;
  localparam int KLEN_W   = 5;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

  // result of one scan step
  typedef struct packed {
    logic                have;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
  } scan_res_t;

endpackage

/* design/jtkf_scan.sv */
// per-byte scanner state and next-state logic of the key finder
module jtkf_scan #(
  parameter int KEY_BYTES         = jtkf_pkg::KEY_BYTES_DEF,
  parameter int MAX_MESSAGE_BYTES = jtkf_pkg::MAX_MESSAGE_BYTES_DEF,
  parameter int DEPTH_BITS        = jtkf_pkg::DEPTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [jtkf_pkg::BYTE_W-1:0]   byte_in,
  input  logic                          eom_in,
  input  logic [jtkf_pkg::KEY_W-1:0]    key_lo,
  input  logic [jtkf_pkg::KEY_W-1:0]    key_hi,
  input  logic [jtkf_pkg::KLEN_W-1:0]   key_len,
  output jtkf_pkg::scan_res_t           res
);

  localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_MESSAGE_BYTES);
  localparam logic [jtkf_pkg::KLEN_W-1:0] KEY_LIMIT = jtkf_pkg::KLEN_W'(KEY_BYTES);
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [5:0] {
    PH_SEEK_ROOT  = 6'b000001,
    PH_SCAN       = 6'b000010,
    PH_STRING     = 6'b000100,
    PH_SEEK_COLON = 6'b001000,
    PH_SEEK_VALUE = 6'b010000,
    PH_DONE       = 6'b100000
  } phase_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  phase_t                      phase_r, phase_nxt;
  logic [DEPTH_BITS-1:0]       depth_r, depth_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;
  logic                        prior_r, prior_nxt;
  logic                        cand_r, cand_nxt;
  logic                        match_r, match_nxt;
  logic [jtkf_pkg::KLEN_W-1:0] kidx_r, kidx_nxt;
  logic                        esc_r, esc_nxt;

  logic [2*jtkf_pkg::KEY_W-1:0] key_all;
  logic [7:0]                   key_byte;
  logic                         key_hit;
  logic [DEPTH_BITS-1:0]        depth_dec;
  logic [PW:0]                  pos_ext;
  logic [PW:0]                  off_sel;
  logic                         have;
  logic [jtkf_pkg::STATUS_W-1:0] status;

  // key byte under the match index
  assign key_all  = {key_hi, key_lo};
  assign key_byte = key_all[{kidx_r[3:0], 3'b000} +: 8];
  assign key_hit  = (kidx_r < key_len) && (kidx_r < KEY_LIMIT) && (key_byte == byte_in);
  assign pos_ext  = {1'b0, pos_r};

  // next state and result of one byte
  always_comb begin
    phase_nxt = phase_r;
    depth_nxt = depth_r;
    pos_nxt   = pos_r;
    prior_nxt = prior_r;
    cand_nxt  = cand_r;
    match_nxt = match_r;
    kidx_nxt  = kidx_r;
    esc_nxt   = esc_r;
    depth_dec = depth_r;
    have      = 1'b0;
    status    = jtkf_pkg::ST_FOUND;
    off_sel   = pos_ext;

    if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end

    if (phase_r != PH_DONE && pos_r >= POS_MAX) begin
      have   = 1'b1;
      status = jtkf_pkg::ST_TOO_LONG;
    end else begin
      unique case (phase_r)
        PH_SEEK_ROOT: begin
          if (!is_ws(byte_in)) begin
            if (byte_in == CH_LBRACE) begin
              phase_nxt = PH_SCAN;
              depth_nxt = DEPTH_ONE;
              prior_nxt = 1'b1;
            end else begin
              have   = 1'b1;
              status = jtkf_pkg::ST_NOT_FOUND;
            end
          end
        end
        PH_SCAN: begin
          if (!is_ws(byte_in)) begin
            if (byte_in == CH_LBRACE || byte_in == CH_LBRACK) begin
              if (depth_r != DEPTH_MAX) depth_nxt = depth_r + 1'b1;
            end else if (byte_in == CH_RBRACE || byte_in == CH_RBRACK) begin
              if (depth_r != '0) depth_dec = depth_r - 1'b1;
              depth_nxt = depth_dec;
              if (depth_dec == '0) begin
                have   = 1'b1;
                status = jtkf_pkg::ST_NOT_FOUND;
              end
            end else if (byte_in == CH_QUOTE) begin
              cand_nxt  = (depth_r == DEPTH_ONE) && prior_r;
              match_nxt = 1'b1;
              kidx_nxt  = '0;
              esc_nxt   = 1'b0;
              phase_nxt = PH_STRING;
            end
            prior_nxt = (byte_in == CH_LBRACE) || (byte_in == CH_COMMA);
          end
        end
        PH_STRING: begin
          if (esc_r) begin
            esc_nxt   = 1'b0;
            match_nxt = 1'b0;
          end else if (byte_in == CH_BSLASH) begin
            esc_nxt   = 1'b1;
            match_nxt = 1'b0;
          end else if (byte_in == CH_QUOTE) begin
            prior_nxt = 1'b0;
            if (cand_r && match_r && kidx_r == key_len) phase_nxt = PH_SEEK_COLON;
            else phase_nxt = PH_SCAN;
          end else if (match_r) begin
            if (key_hit) kidx_nxt = kidx_r + 1'b1;
            else match_nxt = 1'b0;
          end
        end
        PH_SEEK_COLON: begin
          if (!is_ws(byte_in)) begin
            if (byte_in == CH_COLON) begin
              phase_nxt = PH_SEEK_VALUE;
            end else begin
              have   = 1'b1;
              status = jtkf_pkg::ST_MALFORMED;
            end
          end
        end
        PH_SEEK_VALUE: begin
          if (!is_ws(byte_in)) begin
            have   = 1'b1;
            status = jtkf_pkg::ST_FOUND;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    // outcome on the final byte when none came earlier
    if (have) begin
      phase_nxt = PH_DONE;
    end else if (eom_in) begin
      unique case (phase_nxt)
        PH_STRING, PH_SEEK_COLON: begin
          have   = 1'b1;
          status = jtkf_pkg::ST_MALFORMED;
        end
        PH_SEEK_VALUE: begin
          have    = 1'b1;
          status  = jtkf_pkg::ST_FOUND;
          off_sel = pos_ext + 1'b1;
        end
        PH_DONE: begin
        end
        default: begin
          have   = 1'b1;
          status = jtkf_pkg::ST_NOT_FOUND;
        end
      endcase
    end

    // re-arm for the next message
    if (eom_in) begin
      phase_nxt = PH_SEEK_ROOT;
      depth_nxt = '0;
      pos_nxt   = '0;
      prior_nxt = 1'b0;
      cand_nxt  = 1'b0;
      match_nxt = 1'b0;
      kidx_nxt  = '0;
      esc_nxt   = 1'b0;
    end
  end

  assign res.have   = have;
  assign res.status = status;
  assign res.offset = (status == jtkf_pkg::ST_FOUND) ? jtkf_pkg::OFFSET_W'(off_sel) : '0;

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK_ROOT;
      depth_r <= '0;
      pos_r   <= '0;
      prior_r <= 1'b0;
      cand_r  <= 1'b0;
      match_r <= 1'b0;
      kidx_r  <= '0;
      esc_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
      prior_r <= prior_nxt;
      cand_r  <= cand_nxt;
      match_r <= match_nxt;
      kidx_r  <= kidx_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule

/* design/json_top_level_key_finder.sv */
// top level of the json top-level key finder
// Scans a JSON message one byte per transfer and reports where the value of the
// configured root-object member starts, or why it was not found. One byte is
// taken every cycle unless the input stalls; a byte is held in the input register
// while the scan logic updates its state, and its result is registered in the
// output register, which offers it. At most one result comes per message; bytes
// after it up to end_of_message give none. The input stalls only while the output
// register holds a result that is itself stalled. The user must write the key
// registers through the cfg port between messages; the block does not enforce it.
module json_top_level_key_finder #(
  parameter int KEY_BYTES         = jtkf_pkg::KEY_BYTES_DEF,
  parameter int MAX_MESSAGE_BYTES = jtkf_pkg::MAX_MESSAGE_BYTES_DEF,
  parameter int DEPTH_BITS        = jtkf_pkg::DEPTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [jtkf_pkg::BYTE_W-1:0]     in_message_byte,
  input  logic                            in_end_of_message,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [jtkf_pkg::STATUS_W-1:0]   out_status,
  output logic [jtkf_pkg::OFFSET_W-1:0]   out_value_offset,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jtkf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jtkf_pkg::KEY_W-1:0]      cfg_data
);

  logic [jtkf_pkg::KEY_W-1:0]    key_lo_r;
  logic [jtkf_pkg::KEY_W-1:0]    key_hi_r;
  logic [jtkf_pkg::KLEN_W-1:0]   key_len_r;
  logic                          in_valid_r;
  logic [jtkf_pkg::BYTE_W-1:0]   byte_r;
  logic                          eom_r;
  logic                          out_valid_r;
  logic [jtkf_pkg::STATUS_W-1:0] status_r;
  logic [jtkf_pkg::OFFSET_W-1:0] offset_r;
  logic                          pipe_go;
  logic                          step_en;
  jtkf_pkg::scan_res_t           res;

  // pipeline control
  assign pipe_go   = !(out_valid_r && out_stall);
  assign step_en   = in_valid_r && pipe_go;
  assign in_stall  = in_valid_r && !pipe_go;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jtkf_pkg::CFG_KEY_LOW:  key_lo_r  <= cfg_data;
        jtkf_pkg::CFG_KEY_HIGH: key_hi_r  <= cfg_data;
        jtkf_pkg::CFG_KEY_LEN:  key_len_r <= cfg_data[jtkf_pkg::KLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_message_byte;
      eom_r  <= in_end_of_message;
    end
  end

  jtkf_scan #(
    .KEY_BYTES         (KEY_BYTES),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
    .DEPTH_BITS        (DEPTH_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_in (byte_r),
    .eom_in  (eom_r),
    .key_lo  (key_lo_r),
    .key_hi  (key_hi_r),
    .key_len (key_len_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_go) begin
      out_valid_r <= step_en && res.have;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.have) begin
      status_r <= res.status;
      offset_r <= res.offset;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_value_offset = offset_r;

endmodule

/* design/jtkf_checker.sv */
// port-level checks of the json top-level key finder
module jtkf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [jtkf_pkg::STATUS_W-1:0]   out_status,
  input logic [jtkf_pkg::OFFSET_W-1:0]   out_value_offset
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_value_offset))
    else $error("stalled result changed");

  // only a find carries an offset
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != jtkf_pkg::ST_FOUND |-> out_value_offset == '0)
    else $error("offset set on a non-find result");

  // input never stalls while the output drains
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with free output");

  // an input stall always comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind json_top_level_key_finder jtkf_checker u_jtkf_checker (.*);
